FILE: hw/rtl/mct_pkg.sv
// Shared types and constants for the multi-slot countdown timer block.
package mct_pkg;

  // Command codes
  localparam logic [2:0] CMD_SET     = 3'd0;
  localparam logic [2:0] CMD_CANCEL  = 3'd1;
  localparam logic [2:0] CMD_CAPTURE = 3'd2;
  localparam logic [2:0] CMD_RESCHED = 3'd3;
  localparam logic [2:0] CMD_TICK    = 3'd4;

  // Status codes
  localparam logic [1:0] STAT_OK    = 2'd0;
  localparam logic [1:0] STAT_FULL  = 2'd1;
  localparam logic [1:0] STAT_IDLE  = 2'd2;
  localparam logic [1:0] STAT_RANGE = 2'd3;

  // Count value that marks an idle slot
  localparam logic [15:0] IDLE_COUNT = 16'hFFFF;

  // Expiries reported per tick; later ones are freed silently
  localparam int MAX_REPORTS = 8;

  typedef struct packed {
    logic [2:0]  cmd;
    logic [2:0]  slot;
    logic [15:0] period;
    logic [15:0] old_period;
  } in_beat_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [2:0]  slot_id;
    logic [15:0] remaining;
    logic        expired;
    logic        last_of_run;
  } out_beat_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECIDE,
    S_SCAN,
    S_EXEC,
    S_TICK,
    S_TICK_END
  } tmr_state_t;

endpackage

FILE: hw/rtl/multi_slot_countdown_timers_core.sv
// Table of one-shot countdown slots held in one synchronous memory.
//
//   channel | ports                           | beat
//   --------+---------------------------------+----------------------
//   input   | in_valid, in_stall, in_data     | mct_pkg::in_beat_t
//   result  | out_valid, out_stall, out_data  | mct_pkg::out_beat_t
//
// Cancel, unknown and rejected commands answer from the decide state; capture and
// reschedule read the slot count first; set walks the occupied slots ahead of the
// first free one; tick walks every slot on the single memory read port, one slot a cycle unless a stall holds it.
// Reset clears the per-slot active bits; the count memory needs no clear.
// A stalled result holds in the output register; a tick with a second
// expiry to report waits there, other work finishes and waits to load it.
module multi_slot_countdown_timers_core #(
  parameter int NUM_SLOTS = 8
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  mct_pkg::in_beat_t  in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output mct_pkg::out_beat_t out_data
);

  localparam int IW = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
  localparam int CW = $clog2(NUM_SLOTS + 1);

  // State and registers
  mct_pkg::tmr_state_t state_r, state_nxt;
  mct_pkg::in_beat_t   cmd_r;
  mct_pkg::out_beat_t  out_data_r, res;
  logic                out_vld_r;
  logic                out_load;

  logic [15:0]          mem_r [NUM_SLOTS];
  logic [15:0]          rd_data_r;
  logic                 mem_re, mem_we;
  logic [IW-1:0]        mem_raddr, mem_waddr;
  logic [15:0]          mem_wdata;

  logic [NUM_SLOTS-1:0] active_r;
  logic                 act_set, act_clr;
  logic [IW-1:0]        act_idx;

  logic [CW-1:0]        idx_r, idx_nxt;
  logic                 b_vld_r, b_vld_nxt;
  logic [IW-1:0]        b_idx_r, b_idx_nxt;
  logic                 held_vld_r, held_vld_nxt;
  logic [IW-1:0]        held_idx_r, held_idx_nxt;
  logic [3:0]           rep_cnt_r, rep_cnt_nxt;

  // Decoded conditions
  logic [IW-1:0] slot_idx;
  logic [IW-1:0] walk_idx;
  logic          slot_ok, slot_act, period_ok, out_free;
  logic          walk_end, walk_last, tick_done;
  logic [15:0]   dec, elapsed, next_cnt;
  logic          b_act, b_zero, rep_ok, b_report, tick_freeze;

  assign slot_idx  = IW'(cmd_r.slot);
  assign slot_ok   = ({5'd0, cmd_r.slot} < 8'(NUM_SLOTS));
  assign slot_act  = slot_ok && active_r[slot_idx];
  assign period_ok = (cmd_r.period != '0) && (cmd_r.period != mct_pkg::IDLE_COUNT);
  assign out_free  = !out_vld_r || !out_stall;

  assign walk_idx  = idx_r[IW-1:0];
  assign walk_end  = (idx_r == CW'(NUM_SLOTS));
  assign walk_last = (idx_r == CW'(NUM_SLOTS - 1));
  assign tick_done = walk_end && !b_vld_r;

  // Tick stage B: decrement of the slot that stage A read
  assign dec         = rd_data_r - 16'd1;
  assign b_act       = b_vld_r && active_r[b_idx_r];
  assign b_zero      = (dec == '0);
  assign rep_ok      = (rep_cnt_r < 4'(mct_pkg::MAX_REPORTS));
  assign b_report    = b_act && b_zero && rep_ok;
  assign tick_freeze = b_report && held_vld_r && !out_free;

  // Reschedule: keep elapsed time, negative elapsed counts as zero
  assign elapsed  = (cmd_r.old_period > rd_data_r) ? (cmd_r.old_period - rd_data_r) : '0;
  assign next_cnt = (elapsed >= cmd_r.period) ? 16'd1 : (cmd_r.period - elapsed);

  assign in_stall  = (state_r != mct_pkg::S_IDLE);
  assign out_valid = out_vld_r;
  assign out_data  = out_data_r;

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      mct_pkg::S_IDLE: begin
        if (in_valid) state_nxt = mct_pkg::S_DECIDE;
      end
      mct_pkg::S_DECIDE: begin
        unique case (cmd_r.cmd)
          mct_pkg::CMD_SET: begin
            if (period_ok) state_nxt = mct_pkg::S_SCAN;
            else if (out_free) state_nxt = mct_pkg::S_IDLE;
          end
          mct_pkg::CMD_CAPTURE: begin
            if (slot_act) state_nxt = mct_pkg::S_EXEC;
            else if (out_free) state_nxt = mct_pkg::S_IDLE;
          end
          mct_pkg::CMD_RESCHED: begin
            if (slot_act && period_ok) state_nxt = mct_pkg::S_EXEC;
            else if (out_free) state_nxt = mct_pkg::S_IDLE;
          end
          mct_pkg::CMD_TICK: state_nxt = mct_pkg::S_TICK;
          default: begin
            if (out_free) state_nxt = mct_pkg::S_IDLE;
          end
        endcase
      end
      mct_pkg::S_SCAN: begin
        if ((!active_r[walk_idx] || walk_last) && out_free) state_nxt = mct_pkg::S_IDLE;
      end
      mct_pkg::S_EXEC: begin
        if (out_free) state_nxt = mct_pkg::S_IDLE;
      end
      mct_pkg::S_TICK: begin
        if (tick_done) state_nxt = mct_pkg::S_TICK_END;
      end
      mct_pkg::S_TICK_END: begin
        if (out_free) state_nxt = mct_pkg::S_IDLE;
      end
      default: state_nxt = mct_pkg::S_IDLE;
    endcase
  end

  // Datapath controls, result beat and walk registers
  always_comb begin
    out_load        = 1'b0;
    res             = '0;
    res.last_of_run = 1'b1;
    mem_re          = 1'b0;
    mem_raddr       = slot_idx;
    mem_we          = 1'b0;
    mem_waddr       = b_idx_r;
    mem_wdata       = dec;
    act_set         = 1'b0;
    act_clr         = 1'b0;
    act_idx         = slot_idx;
    idx_nxt         = idx_r;
    b_vld_nxt       = b_vld_r;
    b_idx_nxt       = b_idx_r;
    held_vld_nxt    = held_vld_r;
    held_idx_nxt    = held_idx_r;
    rep_cnt_nxt     = rep_cnt_r;
    unique case (state_r)
      mct_pkg::S_IDLE: begin
        idx_nxt = idx_r;
      end
      mct_pkg::S_DECIDE: begin
        idx_nxt      = '0;
        b_vld_nxt    = 1'b0;
        held_vld_nxt = 1'b0;
        rep_cnt_nxt  = '0;
        res.slot_id  = cmd_r.slot;
        unique case (cmd_r.cmd)
          mct_pkg::CMD_SET: begin
            res.slot_id = '0;
            res.status  = mct_pkg::STAT_RANGE;
            out_load    = !period_ok && out_free;
          end
          mct_pkg::CMD_CANCEL: begin
            res.status = slot_act ? mct_pkg::STAT_OK : mct_pkg::STAT_IDLE;
            out_load   = out_free;
            act_clr    = slot_act && out_free;
          end
          mct_pkg::CMD_CAPTURE: begin
            res.status    = mct_pkg::STAT_IDLE;
            res.remaining = mct_pkg::IDLE_COUNT;
            mem_re        = slot_act;
            out_load      = !slot_act && out_free;
          end
          mct_pkg::CMD_RESCHED: begin
            res.status = slot_act ? mct_pkg::STAT_RANGE : mct_pkg::STAT_IDLE;
            mem_re     = slot_act && period_ok;
            out_load   = !(slot_act && period_ok) && out_free;
          end
          mct_pkg::CMD_TICK: begin
            out_load = 1'b0;
          end
          default: begin
            res.status = mct_pkg::STAT_OK;
            out_load   = out_free;
          end
        endcase
      end
      // Set: walk the active bits for the lowest idle slot
      mct_pkg::S_SCAN: begin
        res.slot_id = 3'(walk_idx);
        if (!active_r[walk_idx]) begin
          res.status = mct_pkg::STAT_OK;
          out_load   = out_free;
          mem_we     = out_free;
          mem_waddr  = walk_idx;
          mem_wdata  = cmd_r.period;
          act_set    = out_free;
          act_idx    = walk_idx;
        end else if (walk_last) begin
          res.slot_id = '0;
          res.status  = mct_pkg::STAT_FULL;
          out_load    = out_free;
        end else begin
          idx_nxt = idx_r + CW'(1);
        end
      end
      // Capture or reschedule with the count read in the decide state
      mct_pkg::S_EXEC: begin
        res.slot_id = cmd_r.slot;
        res.status  = mct_pkg::STAT_OK;
        out_load    = out_free;
        if (cmd_r.cmd == mct_pkg::CMD_CAPTURE) begin
          res.remaining = rd_data_r;
        end else begin
          res.remaining = next_cnt;
          mem_we        = out_free;
          mem_waddr     = slot_idx;
          mem_wdata     = next_cnt;
        end
      end
      // Tick: stage A reads a slot, stage B writes back the previous active one or expires it
      mct_pkg::S_TICK: begin
        if (!tick_freeze) begin
          if (!walk_end) begin
            mem_re    = 1'b1;
            mem_raddr = walk_idx;
            b_vld_nxt = 1'b1;
            b_idx_nxt = walk_idx;
            idx_nxt   = idx_r + CW'(1);
          end else begin
            b_vld_nxt = 1'b0;
          end
          if (b_act) begin
            if (b_zero) begin
              act_clr = 1'b1;
              act_idx = b_idx_r;
              if (rep_ok) begin
                // earlier expiry is not the last one: release it now
                if (held_vld_r) begin
                  out_load        = 1'b1;
                  res.slot_id     = 3'(held_idx_r);
                  res.expired     = 1'b1;
                  res.last_of_run = 1'b0;
                end
                held_vld_nxt = 1'b1;
                held_idx_nxt = b_idx_r;
                rep_cnt_nxt  = rep_cnt_r + 4'd1;
              end
            end else begin
              mem_we    = 1'b1;
              mem_waddr = b_idx_r;
              mem_wdata = dec;
            end
          end
        end
      end
      // Final tick beat: held expiry, or a quiet result
      mct_pkg::S_TICK_END: begin
        out_load = out_free;
        if (held_vld_r) begin
          res.slot_id = 3'(held_idx_r);
          res.expired = 1'b1;
        end
      end
      default: begin
        out_load = 1'b0;
      end
    endcase
  end

  // Count memory; reads and writes never hit the same entry in one cycle
  always_ff @(posedge clk) begin
    if (mem_we) mem_r[mem_waddr] <= mem_wdata;
    if (mem_re) rd_data_r <= mem_r[mem_raddr];
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= mct_pkg::S_IDLE;
      active_r   <= '0;
      out_vld_r  <= 1'b0;
      idx_r      <= '0;
      b_vld_r    <= 1'b0;
      held_vld_r <= 1'b0;
      rep_cnt_r  <= '0;
    end else begin
      state_r    <= state_nxt;
      idx_r      <= idx_nxt;
      b_vld_r    <= b_vld_nxt;
      held_vld_r <= held_vld_nxt;
      rep_cnt_r  <= rep_cnt_nxt;
      if (act_set) active_r[act_idx] <= 1'b1;
      else if (act_clr) active_r[act_idx] <= 1'b0;
      if (out_load) out_vld_r <= 1'b1;
      else if (!out_stall) out_vld_r <= 1'b0;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) cmd_r <= in_data;
    if (out_load) out_data_r <= res;
    b_idx_r    <= b_idx_nxt;
    held_idx_r <= held_idx_nxt;
  end

endmodule
